// ===== design/drt_pkg.sv =====
// Shared types, constants and codes of the damage rectangle tracker.
package drt_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 4;

  // Clipping limit for the window registers
  localparam logic [12:0] WIN_MAX = 13'd4096;

  // Operation codes of the mode field
  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_MARK  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WHOLE,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_in;       // capture an input transfer, restart the scan
    logic ld_cur;      // capture the clipped rectangle
    logic idx_inc;     // move to the next entry
    logic wr_merge;    // write the bounding box over the current entry
    logic wr_append;   // append the clipped rectangle
    logic set_full;    // switch to whole-window damage
    logic clr_table;   // empty the table and drop full damage
    logic emit_whole;  // load a whole-window result
    logic emit_entry;  // load the current entry as a result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       drop;        // add is empty, off the window or redundant
    logic       full_damage;
    logic       count_zero;
    logic       idx_end;     // scan or flush has passed the last entry
    logic       hit;         // current entry overlaps or touches
    logic       table_full;
    logic       emit_last;   // current entry is the last one stored
    logic       out_free;    // output register can take a result
  } status_t;

endpackage

// ===== design/drt_ctrl.sv =====
// Controller state machine of the damage rectangle tracker.
module drt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  drt_pkg::status_t  status,
  output drt_pkg::cmd_t     cmd
);

  drt_pkg::state_t state;
  drt_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      drt_pkg::S_IDLE: begin
        if (in_valid) state_next = drt_pkg::S_DECODE;
      end
      drt_pkg::S_DECODE: begin
        case (status.mode)
          drt_pkg::MODE_ADD: begin
            state_next = status.drop ? drt_pkg::S_IDLE : drt_pkg::S_SCAN;
          end
          drt_pkg::MODE_FLUSH: begin
            if (status.full_damage) state_next = drt_pkg::S_WHOLE;
            else if (status.count_zero) state_next = drt_pkg::S_IDLE;
            else state_next = drt_pkg::S_EMIT;
          end
          default: state_next = drt_pkg::S_IDLE;
        endcase
      end
      drt_pkg::S_SCAN: begin
        if (status.idx_end || status.hit) state_next = drt_pkg::S_IDLE;
      end
      drt_pkg::S_WHOLE: begin
        if (status.out_free) state_next = drt_pkg::S_IDLE;
      end
      drt_pkg::S_EMIT: begin
        if (status.out_free && status.emit_last) state_next = drt_pkg::S_IDLE;
      end
      default: state_next = drt_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = (state != drt_pkg::S_IDLE);
    case (state)
      drt_pkg::S_IDLE: begin
        cmd.ld_in = in_valid;
      end
      drt_pkg::S_DECODE: begin
        case (status.mode)
          drt_pkg::MODE_ADD:  cmd.ld_cur = !status.drop;
          drt_pkg::MODE_MARK: cmd.set_full = 1'b1;
          default: ;
        endcase
      end
      drt_pkg::S_SCAN: begin
        if (status.idx_end) begin
          cmd.set_full  = status.table_full;
          cmd.wr_append = !status.table_full;
        end else if (status.hit) begin
          cmd.wr_merge = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      drt_pkg::S_WHOLE: begin
        cmd.emit_whole = status.out_free;
        cmd.clr_table  = status.out_free;
      end
      drt_pkg::S_EMIT: begin
        cmd.emit_entry = status.out_free;
        cmd.idx_inc    = status.out_free && !status.emit_last;
        cmd.clr_table  = status.out_free && status.emit_last;
      end
      default: ;
    endcase
  end

  // A result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_whole || cmd.emit_entry) |-> status.out_free)
    else $error("result loaded into a busy output register");

  // Merge and append never happen together
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_merge && (cmd.wr_append || cmd.set_full)))
    else $error("table written twice for one add");

endmodule

// ===== design/drt_datapath.sv =====
// Datapath of the damage rectangle tracker: window registers, table and output.
module drt_datapath #(
  parameter int CAPACITY = drt_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  drt_pkg::cmd_t     cmd,
  output drt_pkg::status_t  status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic [1:0]        mode,
  input  logic [15:0]       rect_x,
  input  logic [15:0]       rect_y,
  input  logic [15:0]       rect_width,
  input  logic [15:0]       rect_height,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       out_x,
  output logic [11:0]       out_y,
  output logic [12:0]       out_width,
  output logic [12:0]       out_height,
  output logic              whole_window,
  output logic              last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Window registers
  logic [12:0] window_width;
  logic [12:0] window_height;
  logic [12:0] ww;
  logic [12:0] wh;

  // Captured input transfer
  logic [1:0]  in_mode;
  logic [15:0] in_x;
  logic [15:0] in_y;
  logic [15:0] in_w;
  logic [15:0] in_h;

  // Clipped rectangle being added
  logic [11:0] cur_x;
  logic [11:0] cur_y;
  logic [12:0] cur_r;
  logic [12:0] cur_b;

  // Rectangle table
  logic [11:0] tab_left [CAPACITY];
  logic [11:0] tab_top  [CAPACITY];
  logic [12:0] tab_w    [CAPACITY];
  logic [12:0] tab_h    [CAPACITY];
  logic [CW-1:0] rect_count;
  logic          full_damage;
  logic [CW-1:0] idx;

  logic [12:0] rem_w;
  logic [12:0] rem_h;
  logic [12:0] clip_w;
  logic [12:0] clip_h;
  logic        x_off;
  logic        y_off;

  logic [11:0] el;
  logic [11:0] et;
  logic [13:0] er;
  logic [13:0] eb;
  logic [11:0] mx;
  logic [11:0] my;
  logic [13:0] mr;
  logic [13:0] mb;
  logic [13:0] mw;
  logic [13:0] mh;
  logic        out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= '0;
      window_height <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        drt_pkg::CFG_WIDTH:  window_width  <= cfg_data;
        drt_pkg::CFG_HEIGHT: window_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ww = (window_width  > drt_pkg::WIN_MAX) ? drt_pkg::WIN_MAX : window_width;
  assign wh = (window_height > drt_pkg::WIN_MAX) ? drt_pkg::WIN_MAX : window_height;

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_mode <= mode;
      in_x    <= rect_x;
      in_y    <= rect_y;
      in_w    <= rect_width;
      in_h    <= rect_height;
    end
  end

  // Clip to the window
  always_comb begin
    x_off  = ({3'b000, ww} <= in_x);
    y_off  = ({3'b000, wh} <= in_y);
    rem_w  = ww - in_x[12:0];
    rem_h  = wh - in_y[12:0];
    clip_w = (in_w > {3'b000, rem_w}) ? rem_w : in_w[12:0];
    clip_h = (in_h > {3'b000, rem_h}) ? rem_h : in_h[12:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_cur) begin
      cur_x <= in_x[11:0];
      cur_y <= in_y[11:0];
      cur_r <= in_x[12:0] + clip_w;
      cur_b <= in_y[12:0] + clip_h;
    end
  end

  // Current entry and its bounding box with the clipped rectangle
  always_comb begin
    el = tab_left[idx[IW-1:0]];
    et = tab_top[idx[IW-1:0]];
    er = {2'b00, el} + {1'b0, tab_w[idx[IW-1:0]]};
    eb = {2'b00, et} + {1'b0, tab_h[idx[IW-1:0]]};
    mx = (cur_x > el) ? el : cur_x;
    my = (cur_y > et) ? et : cur_y;
    mr = ({1'b0, cur_r} < er) ? er : {1'b0, cur_r};
    mb = ({1'b0, cur_b} < eb) ? eb : {1'b0, cur_b};
    mw = mr - {2'b00, mx};
    mh = mb - {2'b00, my};
  end

  // Table contents
  always_ff @(posedge clk) begin
    if (cmd.wr_merge) begin
      tab_left[idx[IW-1:0]] <= mx;
      tab_top[idx[IW-1:0]]  <= my;
      tab_w[idx[IW-1:0]]    <= mw[12:0];
      tab_h[idx[IW-1:0]]    <= mh[12:0];
    end else if (cmd.wr_append) begin
      tab_left[rect_count[IW-1:0]] <= cur_x;
      tab_top[rect_count[IW-1:0]]  <= cur_y;
      tab_w[rect_count[IW-1:0]]    <= cur_r - {1'b0, cur_x};
      tab_h[rect_count[IW-1:0]]    <= cur_b - {1'b0, cur_y};
    end
  end

  // Fill count and full damage flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_count  <= '0;
      full_damage <= 1'b0;
    end else if (cmd.clr_table) begin
      rect_count  <= '0;
      full_damage <= 1'b0;
    end else if (cmd.set_full) begin
      rect_count  <= '0;
      full_damage <= 1'b1;
    end else if (cmd.wr_append) begin
      rect_count <= rect_count + CW'(1);
    end
  end

  // Scan and flush index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.ld_in) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_whole || cmd.emit_entry) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_whole) begin
      out_x        <= '0;
      out_y        <= '0;
      out_width    <= ww;
      out_height   <= wh;
      whole_window <= 1'b1;
      last         <= 1'b1;
    end else if (cmd.emit_entry) begin
      out_x        <= el;
      out_y        <= et;
      out_width    <= tab_w[idx[IW-1:0]];
      out_height   <= tab_h[idx[IW-1:0]];
      whole_window <= 1'b0;
      last         <= status.emit_last;
    end
  end

  // Status to the controller
  always_comb begin
    status.mode        = in_mode;
    status.drop        = full_damage || (in_w == '0) || (in_h == '0) || x_off || y_off;
    status.full_damage = full_damage;
    status.count_zero  = (rect_count == '0);
    status.idx_end     = (idx >= rect_count);
    status.hit         = !(({1'b0, cur_r} < {2'b00, el}) || (er < {2'b00, cur_x}) ||
                           ({1'b0, cur_b} < {2'b00, et}) || (eb < {2'b00, cur_y}));
    status.table_full  = (rect_count >= CW'(CAPACITY));
    status.emit_last   = ((idx + CW'(1)) == rect_count);
    status.out_free    = out_free;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rect_count <= CW'(CAPACITY))
    else $error("rectangle count above capacity");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    full_damage |-> (rect_count == '0))
    else $error("full damage set with stored rectangles");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_entry && status.emit_last) |=> (rect_count == '0) && out_valid && last)
    else $error("final flush result did not clear the table");

  a_whole_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && whole_window) |-> last)
    else $error("whole-window result without last");

endmodule

// ===== design/damage_rect_tracker_core.sv =====
// A dropped add, mark-all, unused mode or empty flush holds the input while in DECODE;
// a kept add holds it through DECODE and a SCAN of the stored entries that ends with the write.
// A flush loads its first result after DECODE, then one result per cycle while
// the output is not stalled; the input is held until the last result is loaded.
// Throughput: one item in work at a time; the output register frees the input side after that.
// Reset (rst, synchronous) empties the table, clears full damage and the window registers.
module damage_rect_tracker_core #(
  parameter int CAPACITY = drt_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] rect_x,
  input  logic [15:0] rect_y,
  input  logic [15:0] rect_width,
  input  logic [15:0] rect_height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  output logic [12:0] out_width,
  output logic [12:0] out_height,
  output logic        whole_window,
  output logic        last
);

  drt_pkg::cmd_t    cmd;
  drt_pkg::status_t status;

  drt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  drt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_width    (out_width),
    .out_height   (out_height),
    .whole_window (whole_window),
    .last         (last)
  );

endmodule

// ===== sim/damage_region_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the damage regions of the tracker and compares every output transfer.
module damage_region_checker #(
  parameter int CAPACITY = drt_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] rect_x,
  input  logic [15:0] rect_y,
  input  logic [15:0] rect_width,
  input  logic [15:0] rect_height,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_x,
  input  logic [11:0] out_y,
  input  logic [12:0] out_width,
  input  logic [12:0] out_height,
  input  logic        whole_window,
  input  logic        last,
  output int          fail_count,
  output int          regions_due
);

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic        whole;
    logic        last;
  } region_t;

  region_t     due_regions[$];
  logic [12:0] win_width_reg;
  logic [12:0] win_height_reg;
  logic [11:0] ent_left [CAPACITY];
  logic [11:0] ent_top  [CAPACITY];
  logic [12:0] ent_w    [CAPACITY];
  logic [12:0] ent_h    [CAPACITY];
  int          ent_count;
  bit          full_damage;
  int          mismatches = 0;

  task automatic queue_region(input logic [11:0] x, y, input logic [12:0] w, h,
                              input bit whole, input bit fin);
    region_t r;
    r.x     = x;
    r.y     = y;
    r.w     = w;
    r.h     = h;
    r.whole = whole;
    r.last  = fin;
    due_regions.push_back(r);
  endtask

  // Apply one accepted item to the tracked table and queue the regions it emits
  task automatic track_item(input logic [1:0] m, input logic [15:0] px, py, pw, ph);
    int unsigned ww, wh, x, y, w, h, right, bottom, cr, cb;
    int          i;
    bit          merged;
    ww = 32'((win_width_reg > drt_pkg::WIN_MAX) ? drt_pkg::WIN_MAX : win_width_reg);
    wh = 32'((win_height_reg > drt_pkg::WIN_MAX) ? drt_pkg::WIN_MAX : win_height_reg);
    case (m)
      drt_pkg::MODE_ADD: begin
        if (!full_damage && pw != 0 && ph != 0 && px < ww && py < wh) begin
          x = 32'(px);
          y = 32'(py);
          w = 32'(pw);
          h = 32'(ph);
          // Clip to the window
          if (w > ww - x) w = ww - x;
          if (h > wh - y) h = wh - y;
          right  = x + w;
          bottom = y + h;
          merged = 1'b0;
          // Merge into the first entry that overlaps or touches
          for (i = 0; i < ent_count && !merged; i++) begin
            cr = ent_left[i] + ent_w[i];
            cb = ent_top[i] + ent_h[i];
            if (!(right < ent_left[i] || cr < x || bottom < ent_top[i] || cb < y)) begin
              if (x > ent_left[i]) x = ent_left[i];
              if (y > ent_top[i]) y = ent_top[i];
              if (right < cr) right = cr;
              if (bottom < cb) bottom = cb;
              ent_left[i] = x[11:0];
              ent_top[i]  = y[11:0];
              ent_w[i]    = 13'(right - x);
              ent_h[i]    = 13'(bottom - y);
              merged      = 1'b1;
            end
          end
          // Append, or fall back to whole-window damage when the table is full
          if (!merged) begin
            if (ent_count >= CAPACITY) begin
              ent_count   = 0;
              full_damage = 1'b1;
            end else begin
              ent_left[ent_count] = x[11:0];
              ent_top[ent_count]  = y[11:0];
              ent_w[ent_count]    = w[12:0];
              ent_h[ent_count]    = h[12:0];
              ent_count++;
            end
          end
        end
      end
      drt_pkg::MODE_MARK: begin
        ent_count   = 0;
        full_damage = 1'b1;
      end
      drt_pkg::MODE_FLUSH: begin
        if (full_damage) begin
          queue_region(12'd0, 12'd0, ww[12:0], wh[12:0], 1'b1, 1'b1);
        end else begin
          for (i = 0; i < ent_count; i++) begin
            queue_region(ent_left[i], ent_top[i], ent_w[i], ent_h[i], 1'b0,
                         i == ent_count - 1);
          end
        end
        ent_count   = 0;
        full_damage = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Compare one output transfer with the oldest expected region
  task automatic compare_region(input region_t got);
    region_t want;
    bit      bad;
    if (due_regions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t unexpected region: x %0d y %0d w %0d h %0d whole %0b last %0b",
                 $realtime, got.x, got.y, got.w, got.h, got.whole, got.last);
    end else begin
      want = due_regions.pop_front();
      bad  = (got.x != want.x) || (got.y != want.y) || (got.w != want.w) ||
             (got.h != want.h) || (got.whole !== want.whole) || (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t region mismatch: expected x %0d y %0d w %0d h %0d whole %0b last %0b",
                   $realtime, want.x, want.y, want.w, want.h, want.whole, want.last);
          $display("%0t region mismatch: got      x %0d y %0d w %0d h %0d whole %0b last %0b",
                   $realtime, got.x, got.y, got.w, got.h, got.whole, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_regions.delete();
      win_width_reg  = '0;
      win_height_reg = '0;
      ent_count      = 0;
      full_damage    = 1'b0;
    end else begin
      // Check the output transfer first; its item was accepted cycles ago
      if (out_valid && !out_stall)
        compare_region({out_x, out_y, out_width, out_height, whole_window, last});
      // Follow register writes
      if (cfg_we) begin
        if (cfg_index == drt_pkg::CFG_WIDTH) win_width_reg = cfg_data;
        else win_height_reg = cfg_data;
      end
      // Predict the input transfer
      if (in_valid && !in_stall)
        track_item(mode, rect_x, rect_y, rect_width, rect_height);
    end
    regions_due <= due_regions.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the damage tracker testbench: clock, reset, stimulus, output stalls and verdict.
module testbench;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES  = drt_pkg::CAPACITY_DEF + 4;
  localparam int         LONG_HOLD      = 300;
  localparam int         WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_x;
  logic [11:0] out_y;
  logic [12:0] out_width;
  logic [12:0] out_height;
  logic        whole_window;
  logic        last;
  int          fail_count;
  int          regions_due;

  int unsigned span_w = 0;
  int unsigned span_h = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_random = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_taken = 1'b0;
  int          hold_off_cycles = 0;
  int          stall_left = 0;
  int          idle_run = 0;

  damage_rect_tracker_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_width    (out_width),
    .out_height   (out_height),
    .whole_window (whole_window),
    .last         (last)
  );

  damage_region_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_width    (out_width),
    .out_height   (out_height),
    .whole_window (whole_window),
    .last         (last),
    .fail_count   (fail_count),
    .regions_due  (regions_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: long hold-off on request, otherwise random stall runs
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken  = 1'b1;
        hold_off_cycles = LONG_HOLD;
      end
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_random && $urandom_range(0, 99) < 25) begin
        out_stall  <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly near the window, sometimes anywhere in the 16-bit range
  function automatic logic [15:0] pick_coord(int unsigned span);
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, span + span / 8));
  endfunction

  function automatic logic [15:0] pick_size(int unsigned span);
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 16'($urandom_range(0, 65535));
    if (r == 2) return 16'd0;
    return 16'($urandom_range(1, span / 4 + 1));
  endfunction

  // Offer one item after an optional gap and hold it until the transfer
  task automatic send_item(input logic [1:0] m, input logic [15:0] x, y, w, h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    rect_x      <= x;
    rect_y      <= y;
    rect_width  <= w;
    rect_height <= h;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected region has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (regions_due != 0);
  endtask

  // Write both window registers once the block is idle
  task automatic write_window(input logic [12:0] w, input logic [12:0] h);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= drt_pkg::CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= drt_pkg::CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_w = 32'((w > drt_pkg::WIN_MAX) ? drt_pkg::WIN_MAX : w);
    span_h = 32'((h > drt_pkg::WIN_MAX) ? drt_pkg::WIN_MAX : h);
  endtask

  task automatic run_phase(input logic [12:0] w, input logic [12:0] h, input int count,
                           input bit tx_idle, input bit rx_idle);
    int          r;
    logic [1:0]  m;
    write_window(w, h);
    tx_gaps   = tx_idle;
    rx_random = rx_idle;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 68) m = drt_pkg::MODE_ADD;
      else if (r < 73) m = drt_pkg::MODE_MARK;
      else if (r < 95) m = drt_pkg::MODE_FLUSH;
      else m = MODE_UNUSED;
      send_item(m, pick_coord(span_w), pick_coord(span_h), pick_size(span_w),
                pick_size(span_h));
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= drt_pkg::CFG_WIDTH;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    mode        <= drt_pkg::MODE_ADD;
    rect_x      <= '0;
    rect_y      <= '0;
    rect_width  <= '0;
    rect_height <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero window after reset: adds drop, empty flush is silent, whole flush has zero size
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd0, 16'd5, 16'd5);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_MARK, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);

    // Empty and off-window adds, then a full-range rectangle clipped to the window
    write_window(13'd64, 13'd48);
    send_item(drt_pkg::MODE_ADD, 16'd1, 16'd1, 16'd0, 16'd5);
    send_item(drt_pkg::MODE_ADD, 16'd1, 16'd1, 16'd5, 16'd0);
    send_item(drt_pkg::MODE_ADD, 16'd64, 16'd0, 16'd5, 16'd5);
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd48, 16'd5, 16'd5);
    send_item(drt_pkg::MODE_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);

    // Touching edges merge; fill the table; unused mode changes nothing
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd0, 16'd10, 16'd10);
    send_item(drt_pkg::MODE_ADD, 16'd10, 16'd0, 16'd5, 16'd5);
    send_item(drt_pkg::MODE_ADD, 16'd30, 16'd30, 16'd4, 16'd4);
    send_item(drt_pkg::MODE_ADD, 16'd20, 16'd20, 16'd3, 16'd3);
    send_item(drt_pkg::MODE_ADD, 16'd50, 16'd40, 16'd2, 16'd2);
    send_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);

    // Overflow to whole-window damage, later adds ignored
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd0, 16'd2, 16'd2);
    send_item(drt_pkg::MODE_ADD, 16'd10, 16'd0, 16'd2, 16'd2);
    send_item(drt_pkg::MODE_ADD, 16'd20, 16'd0, 16'd2, 16'd2);
    send_item(drt_pkg::MODE_ADD, 16'd30, 16'd0, 16'd2, 16'd2);
    send_item(drt_pkg::MODE_ADD, 16'd40, 16'd0, 16'd2, 16'd2);
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd40, 16'd3, 16'd3);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);

    // Stored rectangles survive a window change
    send_item(drt_pkg::MODE_ADD, 16'd60, 16'd40, 16'd10, 16'd10);
    write_window(13'd16, 13'd16);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);

    // Window registers above range clamp to the limit; far corner clips to one pixel
    write_window(13'h1FFF, 13'h1FFF);
    send_item(drt_pkg::MODE_MARK, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_ADD, 16'd4095, 16'd4095, 16'hFFFF, 16'hFFFF);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);

    // Hold off the receiver while offering back to back, then pause for every region
    write_window(13'd256, 13'd256);
    tx_gaps = 1'b0;
    hold_off_req = 1'b1;
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd0, 16'd8, 16'd8);
    send_item(drt_pkg::MODE_ADD, 16'd40, 16'd0, 16'd8, 16'd8);
    send_item(drt_pkg::MODE_ADD, 16'd80, 16'd0, 16'd8, 16'd8);
    send_item(drt_pkg::MODE_ADD, 16'd120, 16'd0, 16'd8, 16'd8);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_ADD, 16'd0, 16'd100, 16'd8, 16'd8);
    send_item(drt_pkg::MODE_ADD, 16'd100, 16'd100, 16'd8, 16'd8);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_MARK, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_ADD, 16'd200, 16'd200, 16'd100, 16'd100);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(drt_pkg::MODE_FLUSH, 16'd0, 16'd0, 16'd0, 16'd0);
    drain();

    // Random traffic across window settings and idling patterns
    run_phase(13'd4096, 13'd4096, 80, 1'b1, 1'b1);
    run_phase(13'd640, 13'd480, 70, 1'b0, 1'b0);
    run_phase(13'd32, 13'd24, 90, 1'b1, 1'b1);
    run_phase(13'h1FFF, 13'd5000, 60, 1'b1, 1'b0);
    run_phase(13'd1, 13'd1, 35, 1'b0, 1'b1);
    run_phase(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)), 80, 1'b1, 1'b1);

    // Wait out the last regions and any trailing activity
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== damage_rect_tracker_core.f =====
design/drt_pkg.sv
design/drt_ctrl.sv
design/drt_datapath.sv
design/damage_rect_tracker_core.sv
sim/damage_region_checker.sv
sim/testbench.sv
